[sv/dvru_pkg.sv]
// ----------------------------------------------------------------------------
// dvru_pkg: shared types and constants of the distance-vector route table
// Entry layout, status and mode codes, and small helper functions.
// ----------------------------------------------------------------------------
package dvru_pkg;

  typedef struct packed {
    logic [31:0] net;
    logic [5:0]  prefix;
    logic [4:0]  metric;
    logic [31:0] hop;
    logic        direct;
    logic [1:0]  timer;
  } entry_t;

  typedef struct packed {
    logic [31:0] net;
    logic [5:0]  prefix;
  } key_t;

  typedef enum logic {ST_IDLE, ST_RUN} state_e;

  localparam logic [1:0] MODE_ADV     = 2'd0;
  localparam logic [1:0] MODE_TICK    = 2'd1;
  localparam logic [1:0] MODE_RESTART = 2'd2;
  localparam logic [1:0] MODE_UNUSED  = 2'd3;

  localparam logic [2:0] STS_REFRESH  = 3'd0;
  localparam logic [2:0] STS_REPLACE  = 3'd1;
  localparam logic [2:0] STS_INSERT   = 3'd2;
  localparam logic [2:0] STS_IGNORE   = 3'd3;
  localparam logic [2:0] STS_FULL     = 3'd4;
  localparam logic [2:0] STS_DUMP     = 3'd5;
  localparam logic [2:0] STS_EMPTY    = 3'd6;
  localparam logic [2:0] STS_RESTART  = 3'd7;

  localparam logic [2:0] CFG_IFACE0   = 3'd0;
  localparam logic [2:0] CFG_IFACE1   = 3'd1;
  localparam logic [2:0] CFG_IFACE2   = 3'd2;
  localparam logic [2:0] CFG_IFACE3   = 3'd3;
  localparam logic [2:0] CFG_COUNT    = 3'd4;

  localparam logic [4:0] DIST_INF     = 5'd16;
  localparam logic [1:0] ROUTE_TTL    = 2'd3;

  function automatic logic [5:0] sat_prefix(input logic [5:0] p);
    return (p > 6'd32) ? 6'd32 : p;
  endfunction

  function automatic logic [4:0] sat_dist(input logic [5:0] d);
    return (d > 6'd16) ? DIST_INF : d[4:0];
  endfunction

  // p is already saturated to 32; a shift by the full width gives zero.
  function automatic logic [31:0] prefix_mask(input logic [5:0] p);
    return ~(32'hFFFF_FFFF >> p);
  endfunction

endpackage

[sv/distance_vector_route_update.sv]
// Every word is accepted in the idle state; the table then rotates once round
// the chain of cells, the head cell being examined and rewritten at the tail,
// and no new word is taken until the rotation ends. A dump emits one entry per
// cycle while the output is not stalled; a stall holds the rotation. The result
// of an update is registered and given out during the rotation.
// Reset empties the table and sets the interface count to one.
// ----------------------------------------------------------------------------
// distance_vector_route_update: distance-vector route table
// Restart, advertisement and tick handling over a rotating ring of entries.
// ----------------------------------------------------------------------------
module distance_vector_route_update #(
  parameter int TABLE_DEPTH = 32,
  parameter int MAX_IFACES  = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [42:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [31:0] sender_addr_i,
  input  logic [31:0] net_addr_i,
  input  logic [5:0]  prefix_len_i,
  input  logic [4:0]  advert_dist_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [4:0]  entry_index_o,
  output logic [31:0] route_net_o,
  output logic [5:0]  route_prefix_o,
  output logic [4:0]  route_dist_o,
  output logic [31:0] route_next_hop_o,
  output logic        route_direct_o,
  output logic        last_of_run_o
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int TW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IW-1:0] LAST_STEP = IW'(TABLE_DEPTH - 1);
  localparam logic [TW-1:0] FULL_CNT  = TW'(TABLE_DEPTH);
  localparam logic [2:0]    MAX_IF    = 3'(MAX_IFACES);

  localparam logic [2:0] CFG_IFACE0_L = dvru_pkg::CFG_IFACE0;
  localparam logic [2:0] CFG_IFACE1_L = dvru_pkg::CFG_IFACE1;
  localparam logic [2:0] CFG_IFACE2_L = dvru_pkg::CFG_IFACE2;
  localparam logic [2:0] CFG_IFACE3_L = dvru_pkg::CFG_IFACE3;
  localparam logic [2:0] CFG_COUNT_L  = dvru_pkg::CFG_COUNT;

  // configuration
  logic [42:0] iface_q [4];
  logic [2:0]  count_q;
  logic [2:0]  nif;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 4; i++) iface_q[i] <= '0;
      count_q <= 3'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_IFACE0_L: iface_q[0] <= cfg_data_i;
        CFG_IFACE1_L: iface_q[1] <= cfg_data_i;
        CFG_IFACE2_L: iface_q[2] <= cfg_data_i;
        CFG_IFACE3_L: iface_q[3] <= cfg_data_i;
        CFG_COUNT_L:  count_q    <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign nif = (count_q > MAX_IF) ? MAX_IF : count_q;

  // link cost and own-address check for the incoming sender
  logic [4:0] cost;
  logic       mine;
  logic [5:0] in_pre;
  logic [4:0] in_sum;

  always_comb begin
    logic [5:0]  ip;
    logic [31:0] ia;
    logic [31:0] m;
    cost = dvru_pkg::DIST_INF;
    mine = 1'b0;
    for (int i = 3; i >= 0; i--) begin
      ia = iface_q[i][42:11];
      ip = dvru_pkg::sat_prefix(iface_q[i][10:5]);
      m  = dvru_pkg::prefix_mask(ip);
      if (3'(i) < nif) begin
        if ((ia & m) == (sender_addr_i & m)) begin
          cost = dvru_pkg::sat_dist({1'b0, iface_q[i][4:0]});
        end
        if (ia == sender_addr_i) begin
          mine = 1'b1;
        end
      end
    end
    in_pre = dvru_pkg::sat_prefix(prefix_len_i);
    in_sum = dvru_pkg::sat_dist(6'(dvru_pkg::sat_dist({1'b0, advert_dist_i})) + 6'(cost));
  end

  // control
  dvru_pkg::state_e state_q, state_d;
  logic [IW-1:0] k_q, k_d;
  logic [TW-1:0] total_q, total_d;
  logic          found_q, found_d;
  logic          accept, adv;

  // captured word
  logic [1:0]   mode_q;
  logic [31:0]  sender_q;
  logic         mine_q;
  logic [4:0]   sum_q;
  dvru_pkg::key_t key_q;

  assign accept     = in_valid_i && !in_stall_o;
  assign in_stall_o = (state_q != dvru_pkg::ST_IDLE);

  always_ff @(posedge clk_i) begin
    if (accept) begin
      mode_q     <= mode_i;
      sender_q   <= sender_addr_i;
      mine_q     <= mine;
      sum_q      <= in_sum;
      key_q.prefix <= in_pre;
      key_q.net    <= net_addr_i & dvru_pkg::prefix_mask(in_pre);
    end
  end

  // chain of cells
  dvru_pkg::entry_t cell_q [TABLE_DEPTH];
  logic             hit    [TABLE_DEPTH];
  dvru_pkg::entry_t tail;
  logic             shift;

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    dvru_pkg::entry_t nb;
    if (g == TABLE_DEPTH - 1) begin : g_tail
      assign nb = tail;
    end else begin : g_mid
      assign nb = cell_q[g+1];
    end
    dvru_cell u_cell (
      .clk_i  (clk_i),
      .shift_i(shift),
      .ent_i  (nb),
      .key_i  (key_q),
      .ent_o  (cell_q[g]),
      .hit_o  (hit[g])
    );
  end

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dvru_pkg::ST_IDLE: if (accept) state_d = dvru_pkg::ST_RUN;
      dvru_pkg::ST_RUN:  if (adv && k_q == LAST_STEP) state_d = dvru_pkg::ST_IDLE;
      default:           state_d = dvru_pkg::ST_IDLE;
    endcase
  end

  // step datapath: examine the head entry and write it back at the tail
  logic             emit;
  logic             valid_k;
  logic             full_emit;
  dvru_pkg::entry_t cur, upd, conn;
  logic [2:0]       o_sts;
  logic [4:0]       o_idx;
  dvru_pkg::entry_t o_ent;
  logic             o_last;
  logic [5:0]       cp;

  always_comb begin
    cur       = cell_q[0];
    tail      = cur;
    upd       = cur;
    emit      = 1'b0;
    full_emit = 1'b0;
    found_d   = found_q;
    total_d   = total_q;
    o_sts     = dvru_pkg::STS_IGNORE;
    o_idx     = 5'(k_q);
    o_ent     = '0;
    o_last    = 1'b1;
    valid_k   = (TW'(k_q) < total_q);
    cp        = dvru_pkg::sat_prefix(iface_q[k_q[1:0]][10:5]);
    conn.net    = iface_q[k_q[1:0]][42:11] & dvru_pkg::prefix_mask(cp);
    conn.prefix = cp;
    conn.metric = dvru_pkg::sat_dist({1'b0, iface_q[k_q[1:0]][4:0]});
    conn.hop    = '0;
    conn.direct = 1'b1;
    conn.timer  = dvru_pkg::ROUTE_TTL;
    if (state_q == dvru_pkg::ST_RUN) begin
      case (mode_q)
        dvru_pkg::MODE_ADV: begin
          if (valid_k && hit[0] && !found_q) begin
            if (!cur.direct && cur.hop == sender_q) begin
              upd.metric = sum_q;
              upd.timer  = dvru_pkg::ROUTE_TTL;
              o_sts      = dvru_pkg::STS_REFRESH;
            end else if (cur.metric > sum_q && !mine_q) begin
              upd.metric = sum_q;
              upd.timer  = dvru_pkg::ROUTE_TTL;
              upd.hop    = sender_q;
              upd.direct = 1'b0;
              o_sts      = dvru_pkg::STS_REPLACE;
            end else begin
              o_sts = dvru_pkg::STS_IGNORE;
            end
            tail    = upd;
            o_ent   = upd;
            emit    = 1'b1;
            found_d = 1'b1;
          end else if (!found_q && TW'(k_q) == total_q) begin
            upd.net    = key_q.net;
            upd.prefix = key_q.prefix;
            upd.metric = sum_q;
            upd.hop    = sender_q;
            upd.direct = 1'b0;
            upd.timer  = dvru_pkg::ROUTE_TTL;
            tail    = upd;
            o_ent   = upd;
            o_sts   = dvru_pkg::STS_INSERT;
            emit    = 1'b1;
            found_d = 1'b1;
            total_d = total_q + 1'b1;
          end else if (!found_q && k_q == LAST_STEP && total_q == FULL_CNT) begin
            o_sts      = dvru_pkg::STS_FULL;
            o_idx      = '0;
            o_ent.net    = key_q.net;
            o_ent.prefix = key_q.prefix;
            o_ent.metric = sum_q;
            o_ent.hop    = sender_q;
            emit      = 1'b1;
            full_emit = 1'b1;
          end
        end
        dvru_pkg::MODE_TICK: begin
          if (total_q == '0) begin
            emit  = (k_q == LAST_STEP);
            o_sts = dvru_pkg::STS_EMPTY;
            o_idx = '0;
          end else if (valid_k) begin
            emit   = 1'b1;
            o_sts  = dvru_pkg::STS_DUMP;
            o_ent  = cur;
            o_last = (TW'(k_q) + 1'b1 == total_q);
            if (!cur.direct) begin
              if (cur.timer != '0) upd.timer = cur.timer - 1'b1;
              if (upd.timer == '0) upd.metric = dvru_pkg::DIST_INF;
            end
            tail = upd;
          end
        end
        dvru_pkg::MODE_RESTART: begin
          if (3'(k_q) < nif && 32'(k_q) < 32'(nif)) tail = conn;
          emit  = (k_q == LAST_STEP);
          o_sts = dvru_pkg::STS_RESTART;
          o_idx = '0;
          if (k_q == LAST_STEP) total_d = TW'(nif);
        end
        default: begin
          emit  = (k_q == LAST_STEP);
          o_sts = dvru_pkg::STS_IGNORE;
          o_idx = '0;
        end
      endcase
    end
    adv   = (state_q == dvru_pkg::ST_RUN) && !(emit && out_valid_o && out_stall_i);
    shift = adv;
    if (!adv) begin
      found_d = found_q;
      total_d = total_q;
    end
    k_d = adv ? ((k_q == LAST_STEP) ? '0 : k_q + 1'b1) : k_q;
    if (accept) begin
      found_d = 1'b0;
      k_d     = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dvru_pkg::ST_IDLE;
      k_q     <= '0;
      total_q <= '0;
      found_q <= 1'b0;
    end else begin
      state_q <= state_d;
      k_q     <= k_d;
      total_q <= total_d;
      found_q <= found_d;
    end
  end

  // output word register
  logic out_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (emit && adv) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit && adv) begin
      status_o         <= o_sts;
      entry_index_o    <= o_idx;
      route_net_o      <= o_ent.net;
      route_prefix_o   <= o_ent.prefix;
      route_dist_o     <= o_ent.metric;
      route_next_hop_o <= o_ent.hop;
      route_direct_o   <= o_ent.direct;
      last_of_run_o    <= o_last;
    end
  end

  assign out_valid_o = out_vld_q;

  a_total_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    total_q <= FULL_CNT)
    else $error("route count above table depth");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dvru_pkg::ST_RUN && adv && k_q == LAST_STEP)
      |=> (state_q == dvru_pkg::ST_IDLE && k_q == '0))
    else $error("rotation did not end aligned");

  a_adv_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dvru_pkg::ST_RUN && mode_q == dvru_pkg::MODE_ADV && adv
      && k_q == LAST_STEP) |-> (found_d || full_emit))
    else $error("advertisement produced no word");

  a_emit_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dvru_pkg::ST_RUN && mode_q == dvru_pkg::MODE_ADV && found_q)
      |-> !emit)
    else $error("second word for one advertisement");

endmodule

[sv/dvru_cell.sv]
// ----------------------------------------------------------------------------
// dvru_cell: one route table entry in the rotating chain
// Loads its neighbour's entry on every shift and flags a key match.
// ----------------------------------------------------------------------------
module dvru_cell (
  input  logic              clk_i,
  input  logic              shift_i,
  input  dvru_pkg::entry_t  ent_i,
  input  dvru_pkg::key_t    key_i,
  output dvru_pkg::entry_t  ent_o,
  output logic              hit_o
);

  dvru_pkg::entry_t ent_q;

  always_ff @(posedge clk_i) begin
    if (shift_i) begin
      ent_q <= ent_i;
    end
  end

  assign ent_o = ent_q;
  assign hit_o = (ent_q.net == key_i.net) && (ent_q.prefix == key_i.prefix);

endmodule

[tb/tb_distance_vector_route_update.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_distance_vector_route_update: self-checking bench for the route table
// Drives restarts, advertisements and ticks through the valid/stall ports,
// predicts every result word with its own copy of the table and checks them
// in order, over several interface settings and idling patterns.
// ----------------------------------------------------------------------------
module tb_distance_vector_route_update;

  localparam int DEPTH      = 32;
  localparam int SETTLE     = DEPTH + 8;
  localparam int WDOG_LIMIT = 20000;

  typedef struct packed {
    logic [2:0]  status;
    logic [4:0]  idx;
    logic [31:0] net;
    logic [5:0]  pfx;
    logic [4:0]  metric;
    logic [31:0] hop;
    logic        direct;
    logic        last;
  } route_word_t;

  typedef struct {
    logic [1:0]  mode;
    logic [31:0] sender;
    logic [31:0] net;
    logic [5:0]  pfx;
    logic [4:0]  metric;
    bit          typed;
    logic [2:0]  status;
  } advert_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [2:0]  cfg_idx_i;
  logic [42:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [1:0]  mode_i;
  logic [31:0] sender_addr_i;
  logic [31:0] net_addr_i;
  logic [5:0]  prefix_len_i;
  logic [4:0]  advert_dist_i;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [4:0]  entry_index_o;
  logic [31:0] route_net_o;
  logic [5:0]  route_prefix_o;
  logic [4:0]  route_dist_o;
  logic [31:0] route_next_hop_o;
  logic        route_direct_o;
  logic        last_of_run_o;

  distance_vector_route_update uut (.*);

  always #2 clk_i = ~clk_i;

  // Predicted table and interface settings.
  logic [42:0] iface_reg [4];
  logic [2:0]  iface_cnt;
  logic [31:0] tab_net  [DEPTH];
  logic [5:0]  tab_pfx  [DEPTH];
  logic [4:0]  tab_dist [DEPTH];
  logic [31:0] tab_hop  [DEPTH];
  logic        tab_dir  [DEPTH];
  logic [1:0]  tab_timer[DEPTH];
  int          tab_total;

  route_word_t route_words_due[$];
  int          mismatches;
  int          idle_pct;
  int          stall_pct;
  bit          in_taken, out_taken;
  int          quiet_cycles;

  // Per-phase pools that steer advertisements onto existing entries.
  logic [31:0] net_pool[6];
  logic [5:0]  pfx_pool[6];

  function automatic logic [31:0] mask_of(int p);
    return (p == 0) ? 32'd0 : (32'hFFFF_FFFF << (32 - p));
  endfunction

  function automatic int ifaces_in_use();
    return (iface_cnt > 3'd4) ? 4 : int'(iface_cnt);
  endfunction

  function automatic int iface_pfx(int i);
    return (iface_reg[i][10:5] > 6'd32) ? 32 : int'(iface_reg[i][10:5]);
  endfunction

  function automatic int iface_cost(int i);
    return (iface_reg[i][4:0] > 5'd16) ? 16 : int'(iface_reg[i][4:0]);
  endfunction

  function automatic route_word_t entry_word(logic [2:0] st, int i, logic last);
    return '{st, i[4:0], tab_net[i], tab_pfx[i], tab_dist[i], tab_hop[i], tab_dir[i], last};
  endfunction

  function automatic route_word_t bare_word(logic [2:0] st);
    return '{st, 5'd0, 32'd0, 6'd0, 5'd0, 32'd0, 1'b0, 1'b1};
  endfunction

  task automatic predict_update(advert_t a);
    int          n, p, d, cost, sum, hit;
    logic [31:0] net;
    bit          mine;
    n = ifaces_in_use();
    if (a.mode == dvru_pkg::MODE_RESTART) begin
      tab_total = 0;
      for (int i = 0; i < n; i++) begin
        tab_net[i]   = iface_reg[i][42:11] & mask_of(iface_pfx(i));
        tab_pfx[i]   = 6'(iface_pfx(i));
        tab_dist[i]  = 5'(iface_cost(i));
        tab_hop[i]   = '0;
        tab_dir[i]   = 1'b1;
        tab_timer[i] = dvru_pkg::ROUTE_TTL;
        tab_total++;
      end
      route_words_due.push_back(bare_word(dvru_pkg::STS_RESTART));
    end else if (a.mode == dvru_pkg::MODE_TICK) begin
      if (tab_total == 0) begin
        route_words_due.push_back(bare_word(dvru_pkg::STS_EMPTY));
      end else begin
        for (int i = 0; i < tab_total; i++)
          route_words_due.push_back(entry_word(dvru_pkg::STS_DUMP, i, i == tab_total - 1));
        for (int i = 0; i < tab_total; i++) begin
          if (!tab_dir[i]) begin
            if (tab_timer[i] != 0) tab_timer[i]--;
            if (tab_timer[i] == 0) tab_dist[i] = dvru_pkg::DIST_INF;
          end
        end
      end
    end else if (a.mode != dvru_pkg::MODE_ADV) begin
      route_words_due.push_back(bare_word(dvru_pkg::STS_IGNORE));
    end else begin
      p = (a.pfx > 6'd32) ? 32 : int'(a.pfx);
      net = a.net & mask_of(p);
      d = (a.metric > 5'd16) ? 16 : int'(a.metric);
      cost = 16;
      for (int i = n - 1; i >= 0; i--)
        if (((iface_reg[i][42:11] ^ a.sender) & mask_of(iface_pfx(i))) == 0)
          cost = iface_cost(i);
      sum = (d + cost > 16) ? 16 : d + cost;
      mine = 0;
      for (int i = 0; i < n; i++) if (iface_reg[i][42:11] == a.sender) mine = 1;
      hit = -1;
      for (int i = tab_total - 1; i >= 0; i--)
        if (tab_net[i] == net && tab_pfx[i] == p) hit = i;
      if (hit >= 0) begin
        if (!tab_dir[hit] && tab_hop[hit] == a.sender) begin
          tab_dist[hit] = 5'(sum);
          tab_timer[hit] = dvru_pkg::ROUTE_TTL;
          route_words_due.push_back(entry_word(dvru_pkg::STS_REFRESH, hit, 1'b1));
        end else if (tab_dist[hit] > sum && !mine) begin
          tab_dist[hit] = 5'(sum);
          tab_timer[hit] = dvru_pkg::ROUTE_TTL;
          tab_hop[hit] = a.sender;
          tab_dir[hit] = 1'b0;
          route_words_due.push_back(entry_word(dvru_pkg::STS_REPLACE, hit, 1'b1));
        end else begin
          route_words_due.push_back(entry_word(dvru_pkg::STS_IGNORE, hit, 1'b1));
        end
      end else if (tab_total >= DEPTH) begin
        route_words_due.push_back('{dvru_pkg::STS_FULL, 5'd0, net, p[5:0], sum[4:0],
                                    a.sender, 1'b0, 1'b1});
      end else begin
        tab_net[tab_total]   = net;
        tab_pfx[tab_total]   = 6'(p);
        tab_dist[tab_total]  = 5'(sum);
        tab_hop[tab_total]   = a.sender;
        tab_dir[tab_total]   = 1'b0;
        tab_timer[tab_total] = dvru_pkg::ROUTE_TTL;
        route_words_due.push_back(entry_word(dvru_pkg::STS_INSERT, tab_total, 1'b1));
        tab_total++;
      end
    end
  endtask

  // Acceptance is sampled mid-cycle, when every handshake signal is settled.
  always @(negedge clk_i) begin
    route_word_t got, want;
    in_taken  = rst_ni && in_valid_i && !in_stall_o;
    out_taken = rst_ni && out_valid_o && !out_stall_i;
    if (out_taken) begin
      got = '{status_o, entry_index_o, route_net_o, route_prefix_o, route_dist_o,
              route_next_hop_o, route_direct_o, last_of_run_o};
      if (route_words_due.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected word: %p", got);
      end else begin
        want = route_words_due.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
        end
      end
    end
  end

  always @(posedge clk_i) out_stall_i <= ($urandom_range(99) < stall_pct);

  always @(posedge clk_i) begin
    if (!rst_ni || in_taken || out_taken) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Called just after a rising edge; returns after acceptance and idling.
  task automatic send_advert(advert_t a);
    in_valid_i    <= 1'b1;
    mode_i        <= a.mode;
    sender_addr_i <= a.sender;
    net_addr_i    <= a.net;
    prefix_len_i  <= a.pfx;
    advert_dist_i <= a.metric;
    @(negedge clk_i);
    while (!(in_valid_i && !in_stall_o)) @(negedge clk_i);
    predict_update(a);
    if (a.typed) begin
      void'(route_words_due.pop_back());
      route_words_due.push_back(bare_word(a.status));
    end
    @(posedge clk_i);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (route_words_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [42:0] val);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    if (idx == dvru_pkg::CFG_COUNT) iface_cnt = val[2:0];
    else iface_reg[idx[1:0]] = val;
  endtask

  function automatic advert_t random_advert(bit fill);
    advert_t a;
    int      r, k, i;
    a = '{dvru_pkg::MODE_ADV, $urandom(), $urandom(), 6'($urandom_range(0, 63)),
          5'($urandom_range(0, 31)), 1'b0, 3'd0};
    r = $urandom_range(99);
    if (!fill) begin
      if (r < 2) a.mode = dvru_pkg::MODE_RESTART;
      else if (r < 5) a.mode = dvru_pkg::MODE_UNUSED;
      else if (r < 17) a.mode = dvru_pkg::MODE_TICK;
    end
    if (a.mode == dvru_pkg::MODE_ADV) begin
      i = $urandom_range(3);
      r = $urandom_range(99);
      // Mostly neighbours on a configured subnet, some our own addresses.
      if (r < 10) a.sender = iface_reg[i][42:11];
      else if (r < 80)
        a.sender = (iface_reg[i][42:11] & mask_of(iface_pfx(i))) |
                   ($urandom() & ~mask_of(iface_pfx(i)) & 32'h0000_0007);
      if (!fill && $urandom_range(99) < 80) begin
        k = $urandom_range(5);
        a.net = net_pool[k] | ($urandom() & 32'hFF);
        a.pfx = pfx_pool[k];
      end
      if ($urandom_range(99) < 75) a.metric = 5'($urandom_range(0, 16));
    end
    return a;
  endfunction

  advert_t directed[$];
  int      phase_count[4] = '{4, 0, 7, 2};

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = dvru_pkg::CFG_IFACE0;
    cfg_data_i    = '0;
    in_valid_i    = 1'b0;
    mode_i        = dvru_pkg::MODE_ADV;
    sender_addr_i = '0;
    net_addr_i    = '0;
    prefix_len_i  = '0;
    advert_dist_i = '0;
    mismatches    = 0;
    idle_pct      = 0;
    stall_pct     = 0;
    tab_total     = 0;
    iface_cnt     = 3'd1;
    foreach (iface_reg[i]) iface_reg[i] = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty table and the unused mode come before any interface is set up.
    directed.push_back('{dvru_pkg::MODE_TICK, 0, 0, 0, 0, 1'b1, dvru_pkg::STS_EMPTY});
    directed.push_back('{dvru_pkg::MODE_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 6'd63, 5'd31,
                         1'b1, dvru_pkg::STS_IGNORE});
    directed.push_back('{dvru_pkg::MODE_RESTART, 0, 0, 0, 0, 1'b1, dvru_pkg::STS_RESTART});
    directed.push_back('{dvru_pkg::MODE_TICK, 0, 0, 0, 0, 1'b0, 3'd0});
    foreach (directed[j]) send_advert(directed[j]);
    drain();
    directed.delete();

    write_reg(dvru_pkg::CFG_IFACE0, {32'h0A00_0001, 6'd24, 5'd1});
    write_reg(dvru_pkg::CFG_IFACE1, {32'hC0A8_0101, 6'd63, 5'd31});
    write_reg(dvru_pkg::CFG_IFACE2, {32'h0A00_0001, 6'd8, 5'd0});
    write_reg(dvru_pkg::CFG_IFACE3, '1);
    write_reg(dvru_pkg::CFG_COUNT, 43'd7);
    directed.push_back('{dvru_pkg::MODE_RESTART, 0, 0, 0, 0, 1'b1, dvru_pkg::STS_RESTART});
    directed.push_back('{dvru_pkg::MODE_TICK, 0, 0, 0, 0, 1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0005, 32'hFFFF_FFFF, 6'd63, 5'd31,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0005, 32'hAC10_0507, 6'd16, 5'd2,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0005, 32'hAC10_0000, 6'd16, 5'd5,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0009, 32'hAC10_0000, 6'd16, 5'd0,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0001, 32'hAC10_0000, 6'd16, 5'd0,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0005, 32'h0A00_0000, 6'd24, 5'd0,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0102_0304, 32'h0506_0708, 6'd32, 5'd0,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A09_0909, 32'hFFFF_FFFF, 6'd0, 5'd16,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'hFFFF_FFFF, 32'h0000_0000, 6'd32, 5'd16,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'hC0A8_0101, 32'h0A00_0000, 6'd8, 5'd0,
                         1'b0, 3'd0});
    repeat (4) directed.push_back('{dvru_pkg::MODE_TICK, 0, 0, 0, 0, 1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_ADV, 32'h0A00_0005, 32'hAC10_0000, 6'd16, 5'd3,
                         1'b0, 3'd0});
    directed.push_back('{dvru_pkg::MODE_RESTART, 0, 0, 0, 0, 1'b1, dvru_pkg::STS_RESTART});
    foreach (directed[j]) send_advert(directed[j]);

    // Random phases, each with its own interface setting and idling pattern.
    for (int ph = 0; ph < 4; ph++) begin
      drain();
      for (int i = 0; i < 4; i++)
        write_reg(3'(i), {$urandom(), 6'($urandom_range(0, (i == 3) ? 63 : 28)),
                          5'($urandom_range(0, (i == 2) ? 31 : 4))});
      if (ph == 1) write_reg(dvru_pkg::CFG_IFACE0, '0);
      write_reg(dvru_pkg::CFG_COUNT, 43'(phase_count[ph]));
      foreach (net_pool[k]) begin
        pfx_pool[k] = 6'($urandom_range(0, 32));
        net_pool[k] = $urandom();
      end
      idle_pct  = (ph == 1) ? 65 : (ph == 3) ? 30 : 0;
      stall_pct = (ph == 2) ? 65 : (ph == 3) ? 30 : 0;
      send_advert('{dvru_pkg::MODE_RESTART, 0, 0, 0, 0, 1'b0, 3'd0});
      // One phase fills the table with fresh networks to reach the full case.
      if (ph == 0) repeat (36) send_advert(random_advert(1'b1));
      for (int j = 0; j < 90; j++) begin
        if (ph == 2 && j == 45) begin
          in_valid_i <= 1'b0;
          @(posedge clk_i);
          while (route_words_due.size() != 0) @(posedge clk_i);
        end
        send_advert(random_advert(1'b0));
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
